// ===== hdl/hlcc_pkg.sv =====
// Package: shared types, constants and colour codes for the HSV light colour classifier.
`timescale 1ns / 1ps
`default_nettype none

package hlcc_pkg;

    // Tallies saturate here; the tally registers are sized to hold it.
    localparam int MAX_PIXELS = 65536;
    localparam int TALLY_W    = $clog2(MAX_PIXELS + 1);
    localparam int COUNT_W    = 17;

    // Queue between the front and back parts.
    localparam int QDEPTH = 8;
    localparam int QAW    = $clog2(QDEPTH);
    localparam int QCW    = $clog2(QDEPTH + 1);

    localparam logic [1:0] COLOR_UNKNOWN = 2'd0;
    localparam logic [1:0] COLOR_RED     = 2'd1;
    localparam logic [1:0] COLOR_YELLOW  = 2'd2;
    localparam logic [1:0] COLOR_GREEN   = 2'd3;

    typedef struct packed {
        logic [7:0] blue_level;
        logic [7:0] green_level;
        logic [7:0] red_level;
        logic       last_pixel;
    } t_pixel;

    typedef struct packed {
        logic [1:0]         light_color;
        logic [COUNT_W-1:0] red_total;
        logic [COUNT_W-1:0] yellow_total;
        logic [COUNT_W-1:0] green_total;
    } t_result;

    // Band hits of one pixel, as handed from front to back.
    typedef struct packed {
        logic red_hit;
        logic yellow_hit;
        logic green_hit;
        logic last;
    } t_class;

endpackage

`default_nettype wire

// ===== hdl/hlcc_front.sv =====
// Front part: two-stage HSV conversion and colour band test of each pixel.
`timescale 1ns / 1ps
`default_nettype none

module hlcc_front (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    input  wire hlcc_pkg::t_pixel i_pixel,
    output logic                 o_valid,
    output hlcc_pkg::t_class     o_class,
    output logic [1:0]           o_busy
);

    // Hue q = round(num / d) lies in 150..330, hue = q mod 180, so every band
    // maps to one interval of q. Bounds are q >= lo and q < hi (hi exclusive).
    localparam int RED_LO = 160;
    localparam int RED_HI = 180 + 10 + 1;
    localparam int YEL_LO = 180 + 15;
    localparam int YEL_HI = 180 + 35 + 1;
    localparam int GRN_LO = 180 + 40;
    localparam int GRN_HI = 180 + 90 + 1;
    localparam logic [7:0] V_MIN = 8'd100;

    // Stage A
    logic        r_a_valid, n_a_valid;
    logic [7:0]  r_a_mx;
    logic [7:0]  r_a_d;
    logic [18:0] r_a_num;
    logic        r_a_last;
    // Stage B
    logic             r_b_valid;
    hlcc_pkg::t_class r_b_class;

    logic [7:0]  mx, mn, d;
    logic [18:0] b19, g19, r19, d19, num;
    logic [18:0] t, da;
    logic [17:0] s_lhs, s_r100, s_r50;
    logic        in_red, in_yel, in_grn, v_ok, chroma;

    always_comb begin
        mx = i_pixel.red_level;
        mn = i_pixel.red_level;
        if (i_pixel.green_level > mx) mx = i_pixel.green_level;
        if (i_pixel.blue_level  > mx) mx = i_pixel.blue_level;
        if (i_pixel.green_level < mn) mn = i_pixel.green_level;
        if (i_pixel.blue_level  < mn) mn = i_pixel.blue_level;
        d   = mx - mn;
        b19 = {11'd0, i_pixel.blue_level};
        g19 = {11'd0, i_pixel.green_level};
        r19 = {11'd0, i_pixel.red_level};
        d19 = {11'd0, d};
        // Red wins ties, then green.
        if (mx == i_pixel.red_level) begin
            num = 19'd30 * g19 + 19'd180 * d19 - 19'd30 * b19;
        end else if (mx == i_pixel.green_level) begin
            num = 19'd30 * b19 + 19'd240 * d19 - 19'd30 * r19;
        end else begin
            num = 19'd30 * r19 + 19'd300 * d19 - 19'd30 * g19;
        end
        n_a_valid = i_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else begin
            r_a_valid <= n_a_valid;
            r_b_valid <= r_a_valid;
        end
        r_a_mx    <= mx;
        r_a_d     <= d;
        r_a_num   <= num;
        r_a_last  <= i_pixel.last_pixel;
        r_b_class <= '{red_hit: v_ok && chroma && s_lhs >= s_r100 && in_red,
                       yellow_hit: v_ok && chroma && s_lhs >= s_r100 && in_yel,
                       green_hit: v_ok && chroma && s_lhs >= s_r50 && in_grn,
                       last: r_a_last};
    end

    always_comb begin
        da     = {11'd0, r_a_d};
        // 2*num + d against 2*k*d, which is q >= k.
        t      = {r_a_num[17:0], 1'b0} + da;
        // S >= 100 is 510*d >= 199*mx, S >= 50 is 510*d >= 99*mx.
        s_lhs  = 18'd510 * {10'd0, r_a_d};
        s_r100 = 18'd199 * {10'd0, r_a_mx};
        s_r50  = 18'd99  * {10'd0, r_a_mx};
        v_ok   = r_a_mx >= V_MIN;
        chroma = r_a_d != 8'd0;
        in_red = t >= 19'(2 * RED_LO) * da && t < 19'(2 * RED_HI) * da;
        in_yel = t >= 19'(2 * YEL_LO) * da && t < 19'(2 * YEL_HI) * da;
        in_grn = t >= 19'(2 * GRN_LO) * da && t < 19'(2 * GRN_HI) * da;
    end

    assign o_valid = r_b_valid;
    assign o_class = r_b_class;
    assign o_busy  = {1'b0, r_a_valid} + {1'b0, r_b_valid};

endmodule

`default_nettype wire

// ===== hdl/hlcc_queue.sv =====
// Short queue of classified items between the front and back parts.
`timescale 1ns / 1ps
`default_nettype none

module hlcc_queue (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire hlcc_pkg::t_class i_class,
    input  wire logic             i_pop,
    output hlcc_pkg::t_class      o_class,
    output logic                  o_empty,
    output logic [hlcc_pkg::QCW-1:0] o_count
);

    hlcc_pkg::t_class r_mem [hlcc_pkg::QDEPTH];
    logic [hlcc_pkg::QAW-1:0] r_wr, r_rd;
    logic [hlcc_pkg::QCW-1:0] r_count;
    logic do_pop;

    // Pushes are never issued into a full queue: the front holds credit.
    assign do_pop = i_pop && (r_count != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) r_wr <= r_wr + 1'b1;
            if (do_pop) r_rd <= r_rd + 1'b1;
            if (i_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && do_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
        if (i_push) r_mem[r_wr] <= i_class;
    end

    assign o_class = r_mem[r_rd];
    assign o_empty = r_count == '0;
    assign o_count = r_count;

endmodule

`default_nettype wire

// ===== hdl/hlcc_back.sv =====
// Back part: saturating tallies, end-of-crop decision and result register.
`timescale 1ns / 1ps
`default_nettype none

module hlcc_back (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire hlcc_pkg::t_class i_class,
    input  wire logic             i_q_empty,
    output logic                  o_q_pop,
    input  wire logic             i_pop,
    output logic                  o_empty,
    output hlcc_pkg::t_result     o_result
);

    localparam int TW = hlcc_pkg::TALLY_W;
    localparam int MW = hlcc_pkg::TALLY_W + 5;
    localparam int CW = hlcc_pkg::COUNT_W;
    localparam logic ST_IDLE   = 1'b0;
    localparam logic ST_DECIDE = 1'b1;
    localparam logic [TW-1:0] SAT = TW'(hlcc_pkg::MAX_PIXELS);

    logic r_state, n_state;
    logic [TW-1:0] r_red, r_yel, r_grn, r_tot;
    logic [TW-1:0] n_red, n_yel, n_grn, n_tot;
    logic r_out_valid, n_out_valid;
    hlcc_pkg::t_result r_out, n_out;

    logic [MW-1:0] red20, yel20, grn20, tot_x;
    logic [TW+CW-1:0] red_x, yel_x, grn_x;
    logic [1:0] color;
    logic load;

    function automatic logic [TW-1:0] sat_inc(input logic [TW-1:0] v, input logic hit);
        logic [TW-1:0] res;
        res = v;
        if (hit && v < SAT) res = v + 1'b1;
        return res;
    endfunction

    always_comb begin
        red20 = ({5'd0, r_red} << 4) + ({5'd0, r_red} << 2);
        yel20 = ({5'd0, r_yel} << 4) + ({5'd0, r_yel} << 2);
        grn20 = ({5'd0, r_grn} << 4) + ({5'd0, r_grn} << 2);
        tot_x = {5'd0, r_tot};
        if (r_red > r_yel && r_red > r_grn && red20 > tot_x) begin
            color = hlcc_pkg::COLOR_RED;
        end else if (r_grn > r_yel && r_grn > r_red && grn20 > tot_x) begin
            color = hlcc_pkg::COLOR_GREEN;
        end else if (yel20 > tot_x) begin
            color = hlcc_pkg::COLOR_YELLOW;
        end else begin
            color = hlcc_pkg::COLOR_UNKNOWN;
        end
        red_x = {{CW{1'b0}}, r_red};
        yel_x = {{CW{1'b0}}, r_yel};
        grn_x = {{CW{1'b0}}, r_grn};
    end

    always_comb begin
        n_state     = r_state;
        n_red       = r_red;
        n_yel       = r_yel;
        n_grn       = r_grn;
        n_tot       = r_tot;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_pop;
        o_q_pop     = 1'b0;
        load        = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (!i_q_empty) begin
                    o_q_pop = 1'b1;
                    n_red   = sat_inc(r_red, i_class.red_hit);
                    n_yel   = sat_inc(r_yel, i_class.yellow_hit);
                    n_grn   = sat_inc(r_grn, i_class.green_hit);
                    n_tot   = sat_inc(r_tot, 1'b1);
                    if (i_class.last) n_state = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                // Wait here until the result register is free.
                if (!r_out_valid || i_pop) begin
                    load        = 1'b1;
                    n_out       = '{light_color: color,
                                    red_total: red_x[CW-1:0],
                                    yellow_total: yel_x[CW-1:0],
                                    green_total: grn_x[CW-1:0]};
                    n_out_valid = 1'b1;
                    n_red       = '0;
                    n_yel       = '0;
                    n_grn       = '0;
                    n_tot       = '0;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_red       <= '0;
            r_yel       <= '0;
            r_grn       <= '0;
            r_tot       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_red       <= n_red;
            r_yel       <= n_yel;
            r_grn       <= n_grn;
            r_tot       <= n_tot;
            r_out_valid <= n_out_valid;
        end
        if (load) r_out <= n_out;
    end

    assign o_empty  = !r_out_valid;
    assign o_result = r_out;

endmodule

`default_nettype wire

// ===== hdl/hsv_light_color_classifier_unit.sv =====
// Top level: HSV traffic light colour classifier, front, queue and back.
//
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+---------------------------
//  pixel    | in        | push / full        | i_pixel  (hlcc_pkg::t_pixel)
//  result   | out       | empty / pop        | o_result (hlcc_pkg::t_result)
//
// One pixel a cycle enters while full is low; each pixel passes through the
// two front stages and the queue; the back pops it and updates the tallies.
// A last pixel sends the back into a decision state that loads the result
// register, and waits there while an older result is unread.
// full rises when the queue plus the two front stages hold QDEPTH items.
// Reset is synchronous and clears all tallies and handshake state.
`timescale 1ns / 1ps
`default_nettype none

module hsv_light_color_classifier_unit (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              push,
    output logic                   full,
    input  wire hlcc_pkg::t_pixel  i_pixel,
    output logic                   empty,
    input  wire logic              pop,
    output hlcc_pkg::t_result      o_result
);

    logic                      f_valid;
    hlcc_pkg::t_class          f_class;
    logic [1:0]                f_busy;
    hlcc_pkg::t_class          q_class;
    logic                      q_empty;
    logic                      q_pop;
    logic [hlcc_pkg::QCW-1:0]  q_count;
    logic [hlcc_pkg::QCW:0]    held;
    logic                      take;

    // Items in the front stages already own a queue slot.
    assign held = {1'b0, q_count} + (hlcc_pkg::QCW + 1)'(f_busy);
    assign full = held >= (hlcc_pkg::QCW + 1)'(hlcc_pkg::QDEPTH);
    assign take = push && !full;

    hlcc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (take),
        .i_pixel (i_pixel),
        .o_valid (f_valid),
        .o_class (f_class),
        .o_busy  (f_busy)
    );

    hlcc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_valid),
        .i_class (f_class),
        .i_pop   (q_pop),
        .o_class (q_class),
        .o_empty (q_empty),
        .o_count (q_count)
    );

    hlcc_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_class   (q_class),
        .i_q_empty (q_empty),
        .o_q_pop   (q_pop),
        .i_pop     (pop),
        .o_empty   (empty),
        .o_result  (o_result)
    );

endmodule

`default_nettype wire

// ===== hdl/hlcc_checker.sv =====
// Checker: port-level assertions for the classifier, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module hlcc_checker (
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              push,
    input wire logic              full,
    input wire hlcc_pkg::t_pixel  i_pixel,
    input wire logic              empty,
    input wire logic              pop,
    input wire hlcc_pkg::t_result o_result
);

    // A waiting result stays put until it is taken.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !pop |=> !empty && $stable(o_result))
        else $error("result changed while waiting");

    // Reset leaves nothing to read and room to write.
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> empty && !full)
        else $error("reset did not clear the handshake state");

    a_red: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && o_result.light_color == hlcc_pkg::COLOR_RED |->
        o_result.red_total > o_result.yellow_total &&
        o_result.red_total > o_result.green_total)
        else $error("red reported without a red majority");

    a_green: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && o_result.light_color == hlcc_pkg::COLOR_GREEN |->
        o_result.green_total > o_result.yellow_total &&
        o_result.green_total > o_result.red_total)
        else $error("green reported without a green majority");

endmodule

bind hsv_light_color_classifier_unit hlcc_checker u_hlcc_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .push     (push),
    .full     (full),
    .i_pixel  (i_pixel),
    .empty    (empty),
    .pop      (pop),
    .o_result (o_result)
);

`default_nettype wire
